/* rtl/pit_pkg.sv */
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the point-in-polygon test
// Holds the sequencer state type, command codes and register layout.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Width of the vertex_count register.
  localparam int VCOUNT_W = 7;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index of vertex_count.
  localparam logic REG_VCOUNT = 1'b0;

  // Query sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } pit_state_t;

endpackage

/* rtl/point_in_polygon_test.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number test over a stored polygon
// A vertex store in a synchronous memory holds the corners. A query walks
// every edge, one edge per cycle, through a three-stage arithmetic pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | in_cmd, in_vertex_index, in_coord_x/y   | start high, busy low
//  result   | out_inside_res, out_was_query           | out_valid for one cycle
//  config   | psel, penable, pwrite, paddr, pwdata    | APB, pready always high
//
// A write word is acknowledged in the next cycle and the block can take a new
// word in that same cycle. A query makes one memory read per edge plus one for
// the closing corner, then lets the read and multiply pipeline drain; with no
// vertices in use it answers in the next cycle.
// Reset clears the control state only; the vertex store is not cleared.
// The receiver cannot stall results, so no output buffering is needed.

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [5:0]            in_vertex_index,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  // Result channel
  output logic                  out_valid,
  output logic                  out_inside_res,
  output logic                  out_was_query,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pit_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * C + 2;

  // Configuration register.
  logic [VCOUNT_W-1:0] vcount_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_VCOUNT)) begin
      vcount_r <= pwdata[VCOUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VCOUNT) begin
      prdata = 32'(vcount_r);
    end
  end

  // Vertex count in use, saturated to the store depth.
  logic [31:0] vcount_ext;
  logic [CW-1:0] nsat;
  assign vcount_ext = 32'(vcount_r);
  assign nsat = (vcount_ext > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_ext);

  // Input acceptance.
  logic accept;
  logic idx_ok;
  assign accept = start && !busy;
  assign idx_ok = 32'(in_vertex_index) < 32'(MAX_VERTICES);

  // Sequencer.
  pit_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          s0_vld_r, s0_first_r, s1_vld_r, s2_vld_r;
  logic          drained;

  assign drained = !s0_vld_r && !s1_vld_r && !s2_vld_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY) && (nsat != '0)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        cnt_nxt = '0;
      end
      ST_RUN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // The first read fetches the closing corner, then corners 0 to n-1 follow.
  assign raddr = (cnt_r == '0) ? AW'(n_r - CW'(1)) : AW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Vertex store: x in the upper half, y in the lower half.
  logic [2*C-1:0] mem [MAX_VERTICES];
  logic [2*C-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_WRITE) && idx_ok) begin
      mem[AW'(32'(in_vertex_index))] <= {in_coord_x, in_coord_y};
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Query point and element bookkeeping.
  logic signed [C:0] px_r, py_r;
  logic [2*C-1:0]    prev_r;

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_QUERY)) begin
      px_r <= {in_coord_x[C-1], in_coord_x};
      py_r <= {in_coord_y[C-1], in_coord_y};
      n_r  <= nsat;
    end
    if (s0_vld_r) begin
      prev_r <= rdata_r;
    end
  end

  // Stage 1: edge differences, normalized so that the divisor is non-negative.
  logic signed [C:0] xi, yi, xj, yj, dy, dx, dp, t;
  logic              spans_y;
  logic signed [C:0] s1_dx_r, s1_dp_r, s1_t_r, s1_d_r;
  logic              s1_cross_r;

  assign xi = {rdata_r[2*C-1], rdata_r[2*C-1:C]};
  assign yi = {rdata_r[C-1], rdata_r[C-1:0]};
  assign xj = {prev_r[2*C-1], prev_r[2*C-1:C]};
  assign yj = {prev_r[C-1], prev_r[C-1:0]};
  assign dy = yj - yi;
  assign dx = xj - xi;
  assign dp = py_r - yi;
  assign t  = px_r - xi;
  assign spans_y = (yi > py_r) != (yj > py_r);

  always_ff @(posedge clk) begin
    s1_cross_r <= spans_y;
    s1_dp_r    <= dp;
    s1_t_r     <= t;
    if (dy < 0) begin
      s1_dx_r <= -dx;
      s1_d_r  <= -dy;
    end else begin
      s1_dx_r <= dx;
      s1_d_r  <= dy;
    end
  end

  // Stage 2: numerator and the scaled point offset.
  logic signed [PW-1:0] s2_num_r, s2_td_r;
  logic signed [C:0]    s2_d_r;
  logic                 s2_cross_r;

  always_ff @(posedge clk) begin
    s2_num_r   <= PW'(s1_dx_r) * PW'(s1_dp_r);
    s2_td_r    <= PW'(s1_t_r) * PW'(s1_d_r);
    s2_d_r     <= s1_d_r;
    s2_cross_r <= s1_cross_r;
  end

  // Stage 3: px - xi < trunc(num / d) without dividing.
  logic signed [PW:0] num_e, td_e, tdd_e;
  logic               hit;
  assign num_e = {s2_num_r[PW-1], s2_num_r};
  assign td_e  = {s2_td_r[PW-1], s2_td_r};
  assign tdd_e = td_e + (PW+1)'(s2_d_r);
  assign hit   = (num_e >= 0) ? (tdd_e <= num_e) : (td_e < num_e);

  // Pipeline valid bits and the crossing flag.
  logic inside_r;
  logic out_valid_r, out_inside_r, out_query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r   <= 1'b0;
      s0_first_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      inside_r   <= 1'b0;
    end else begin
      s0_vld_r   <= rd_en;
      s0_first_r <= rd_en && (cnt_r == '0);
      s1_vld_r   <= s0_vld_r && !s0_first_r;
      s2_vld_r   <= s1_vld_r;
      if (accept && (in_cmd == CMD_QUERY)) begin
        inside_r <= 1'b0;
      end else if (s2_vld_r && s2_cross_r && hit) begin
        inside_r <= !inside_r;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_inside_r <= 1'b0;
      out_query_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (accept && (in_cmd == CMD_WRITE)) begin
        out_valid_r  <= 1'b1;
        out_inside_r <= 1'b0;
        out_query_r  <= 1'b0;
      end else if (accept && (nsat == '0)) begin
        out_valid_r  <= 1'b1;
        out_inside_r <= 1'b0;
        out_query_r  <= 1'b1;
      end else if ((state_r == ST_DRAIN) && drained) begin
        out_valid_r  <= 1'b1;
        out_inside_r <= inside_r;
        out_query_r  <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_was_query  = out_query_r;

endmodule

/* rtl/pit_checker.sv */
// ----------------------------------------------------------------------------
// pit_checker: port-level checks of the point-in-polygon test
// Watches the handshake and result ports over time.
// ----------------------------------------------------------------------------
module pit_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_cmd,
  input logic out_valid,
  input logic out_inside_res,
  input logic out_was_query
);
  import pit_pkg::*;

  // A write word is acknowledged in the next cycle.
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_WRITE) |=> out_valid && !out_was_query)
    else $error("write not acknowledged");

  // A write acknowledgment never reports inside.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_query |-> !out_inside_res)
    else $error("write result flagged inside");

  // A query either keeps the block busy or answers at once.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_QUERY) |=> busy || (out_valid && out_was_query))
    else $error("query dropped");

  // No result and no busy flag right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity after reset");

endmodule

bind point_in_polygon_test pit_checker u_pit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_inside_res (out_inside_res),
  .out_was_query  (out_was_query)
);
